### src/fust_pkg.sv
// Shared constants, types and helpers for the first unique symbol tracker.
package fust_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int SYM_W         = 5;
  localparam int POS_W         = 16;
  localparam int CNT_W         = 2;
  localparam int IDX_W         = $clog2(ALPHABET_SIZE);
  localparam int FILL_W        = $clog2(ALPHABET_SIZE + 1);

  localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_NONE   = CNT_W'(0);
  localparam logic [CNT_W-1:0]  CNT_ONCE   = CNT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_MULTI  = CNT_W'(2);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(ALPHABET_SIZE);
  localparam logic [FILL_W-1:0] FILL_EMPTY = FILL_W'(0);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EVICT
  } state_t;

  // Control to the occurrence count array
  typedef struct packed {
    logic clear;
    logic inc;
  } cnt_ctl_t;

  // Control to the arrival-order queue
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } q_ctl_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_W'(ALPHABET_SIZE - 1)) ? IDX_W'(0) : idx + IDX_W'(1);
  endfunction

  function automatic logic sym_in_range(input logic [SYM_W-1:0] sym);
    sym_in_range = ({1'b0, sym} < (SYM_W + 1)'(ALPHABET_SIZE));
  endfunction

endpackage

### src/fust_count.sv
// Per-symbol occurrence counters, saturating, with one shared read port.
module fust_count
  import fust_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cnt_ctl_t         ctl,
  input  logic [IDX_W-1:0] addr,
  output logic [CNT_W-1:0] rd_count
);

  logic [CNT_W-1:0] cnt_r   [ALPHABET_SIZE];
  logic [CNT_W-1:0] cnt_nxt [ALPHABET_SIZE];

  // A clear on the same beat makes every symbol read as unseen
  assign rd_count = ctl.clear ? CNT_NONE : cnt_r[addr];

  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      cnt_nxt[i] = ctl.clear ? CNT_NONE : cnt_r[i];
    end
    if (ctl.inc && (rd_count != CNT_MULTI)) begin
      cnt_nxt[addr] = rd_count + CNT_ONCE;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (!rst_n) begin
        cnt_r[i] <= CNT_NONE;
      end else begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

### src/fust_queue.sv
// Arrival-order ring queue of symbol and position pairs.
module fust_queue
  import fust_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_ctl_t            ctl,
  input  logic [SYM_W-1:0]  push_sym,
  input  logic [POS_W-1:0]  push_pos,
  output logic [SYM_W-1:0]  head_sym,
  output logic [POS_W-1:0]  head_pos,
  output logic [FILL_W-1:0] fill
);

  logic [SYM_W-1:0]  sym_r [ALPHABET_SIZE];
  logic [POS_W-1:0]  pos_r [ALPHABET_SIZE];
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  tail_base;
  logic [FILL_W-1:0] fill_base;
  logic              push_ok;

  assign head_sym = sym_r[head_r];
  assign head_pos = pos_r[head_r];
  assign fill     = fill_r;

  always_comb begin
    tail_base = ctl.clear ? IDX_W'(0) : tail_r;
    fill_base = ctl.clear ? FILL_EMPTY : fill_r;
    push_ok   = ctl.push && (fill_base != FILL_FULL);
    head_nxt  = ctl.clear ? IDX_W'(0) : head_r;
    tail_nxt  = tail_base;
    fill_nxt  = fill_base;
    if (push_ok) begin
      tail_nxt = ring_next(tail_base);
      fill_nxt = fill_base + FILL_W'(1);
    end else if (ctl.pop && (fill_base != FILL_EMPTY)) begin
      head_nxt = ring_next(head_r);
      fill_nxt = fill_base - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= IDX_W'(0);
      tail_r <= IDX_W'(0);
      fill_r <= FILL_EMPTY;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      sym_r[tail_base] <= push_sym;
      pos_r[tail_base] <= push_pos;
    end
  end

endmodule

### src/fust_ctrl.sv
// Sequencer: takes a symbol, updates count and queue, then evicts stale heads.
module fust_ctrl
  import fust_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_first_of_string,
  input  logic              out_free,
  input  logic [CNT_W-1:0]  rd_count,
  input  logic [SYM_W-1:0]  head_sym,
  input  logic [FILL_W-1:0] fill,
  output logic              in_stall,
  output cnt_ctl_t          cnt_ctl,
  output logic [IDX_W-1:0]  cnt_addr,
  output q_ctl_t            q_ctl,
  output logic [POS_W-1:0]  push_pos,
  output logic              done,
  output logic              overflow
);

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic             sym_ok;
  logic             pop;

  assign sym_ok   = sym_in_range(in_symbol);
  assign overflow = ovf_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall      = 1'b1;
    accept        = 1'b0;
    cnt_addr      = IDX_W'(head_sym);
    cnt_ctl.clear = 1'b0;
    cnt_ctl.inc   = 1'b0;
    q_ctl.clear   = 1'b0;
    q_ctl.push    = 1'b0;
    q_ctl.pop     = 1'b0;
    pop           = 1'b0;
    done          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        accept        = in_valid;
        cnt_addr      = IDX_W'(in_symbol);
        cnt_ctl.clear = accept && in_first_of_string;
        cnt_ctl.inc   = accept && sym_ok;
        q_ctl.clear   = accept && in_first_of_string;
        q_ctl.push    = accept && sym_ok && (rd_count == CNT_NONE);
      end
      ST_EVICT: begin
        // Drop the head while its symbol has repeated; report once it holds
        pop       = (fill != FILL_EMPTY) && (rd_count == CNT_MULTI);
        q_ctl.pop = pop;
        done      = !pop && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Position counter and overflow flag
  always_comb begin
    push_pos = in_first_of_string ? POS_W'(0) : pos_r;
    pos_nxt  = pos_r;
    ovf_nxt  = ovf_r;
    if (accept) begin
      pos_nxt = push_pos;
      ovf_nxt = in_first_of_string ? 1'b0 : ovf_r;
      if (sym_ok) begin
        if (push_pos == POS_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          pos_nxt = push_pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= POS_W'(0);
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

### src/first_unique_symbol_tracker_unit.sv
// First unique symbol tracker: top level with result register.
// After an accepted beat the controller pops each stale queue head, then registers the result once the output is free.
// A new symbol is taken only after the eviction loop for the previous one has finished; each entry is
// evicted once, so the evictions over a string never exceed the entries pushed for it.
// A waiting result does not block the next beat from entering; the new result is held back until the output is free.
// Reset (rst_n low, synchronous) clears counts, queue pointers, position and overflow.
module first_unique_symbol_tracker_unit
  import fust_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_first_of_string,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_has_unique,
  output logic [POS_W-1:0] out_unique_position,
  output logic [SYM_W-1:0] out_unique_symbol,
  output logic             out_position_overflow
);

  cnt_ctl_t          cnt_ctl;
  q_ctl_t            q_ctl;
  logic [IDX_W-1:0]  cnt_addr;
  logic [CNT_W-1:0]  rd_count;
  logic [SYM_W-1:0]  head_sym;
  logic [POS_W-1:0]  head_pos;
  logic [FILL_W-1:0] fill;
  logic [POS_W-1:0]  push_pos;
  logic              done;
  logic              overflow;
  logic              out_free;
  logic              has_unique;

  logic             out_valid_r, out_valid_nxt;
  logic             has_r;
  logic [POS_W-1:0] upos_r;
  logic [SYM_W-1:0] usym_r;
  logic             ovf_out_r;

  fust_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_symbol          (in_symbol),
    .in_first_of_string (in_first_of_string),
    .out_free           (out_free),
    .rd_count           (rd_count),
    .head_sym           (head_sym),
    .fill               (fill),
    .in_stall           (in_stall),
    .cnt_ctl            (cnt_ctl),
    .cnt_addr           (cnt_addr),
    .q_ctl              (q_ctl),
    .push_pos           (push_pos),
    .done               (done),
    .overflow           (overflow)
  );

  fust_count u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cnt_ctl),
    .addr     (cnt_addr),
    .rd_count (rd_count)
  );

  fust_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (q_ctl),
    .push_sym (in_symbol),
    .push_pos (push_pos),
    .head_sym (head_sym),
    .head_pos (head_pos),
    .fill     (fill)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign has_unique = (fill != FILL_EMPTY);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result beat; zero the fields when nothing unique remains
  always_ff @(posedge clk) begin
    if (done) begin
      has_r     <= has_unique;
      upos_r    <= has_unique ? head_pos : POS_W'(0);
      usym_r    <= has_unique ? head_sym : SYM_W'(0);
      ovf_out_r <= overflow;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_has_unique        = has_r;
  assign out_unique_position   = upos_r;
  assign out_unique_symbol     = usym_r;
  assign out_position_overflow = ovf_out_r;

endmodule
